@@ hdl/hbepm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hbepm_pkg
// Shared types and constants for the half-duplex bus echo / frame queue block.
// ----------------------------------------------------------------------------
package hbepm_pkg;

  localparam int EchoDepth  = 64;
  localparam int QueueSlots = 16;
  localparam int SlotBytes  = 64;

  localparam int EchoAw  = $clog2(EchoDepth);
  localparam int SlotAw  = $clog2(QueueSlots);
  localparam int ByteAw  = $clog2(SlotBytes);
  localparam int FrameAw = SlotAw + ByteAw;
  localparam int EchoCw  = EchoAw + 1;
  localparam int FillCw  = ByteAw + 1;
  localparam int CountW  = SlotAw + 1;

  // event kinds
  localparam logic [2:0] KIND_TXE   = 3'd0;
  localparam logic [2:0] KIND_RXE   = 3'd1;
  localparam logic [2:0] KIND_NODE  = 3'd2;
  localparam logic [2:0] KIND_XON   = 3'd3;
  localparam logic [2:0] KIND_XOFF  = 3'd4;
  localparam logic [2:0] KIND_TICK  = 3'd5;
  localparam logic [2:0] KIND_EXT   = 3'd6;

  // result destinations
  localparam logic [1:0] DEST_NODE  = 2'd0;
  localparam logic [1:0] DEST_NET   = 2'd1;
  localparam logic [1:0] DEST_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [1:0] dest;
    logic [7:0] data;
    logic [6:0] frame_len;
    logic       truncated;
    logic       end_of_run;
  } out_item_t;

  // controller -> datapath commands
  typedef struct packed {
    logic latch;       // capture the input beat and decode it
    logic echo_rd;     // read echo store at echo pointer (replay position with frame_rd)
    logic frame_rd;    // read frame store at head slot
    logic emit_echo;   // result from echo read data (network frame)
    logic emit_empty;  // empty frame result
    logic emit_tick_e; // tick echo result
    logic emit_tick_q; // tick queue result
    logic step_ptr;    // advance the emission pointer
    logic finish;      // apply end-of-item state updates
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic tx_off_evt;  // txe disable while transmit is enabled
    logic tx_empty;    // echo frame is empty
    logic tick_echo;   // tick delivers an echo byte
    logic tick_queue;  // tick delivers a queued byte
    logic ptr_last;    // emitted byte is the final echo byte
  } stat_t;

endpackage

`default_nettype wire

@@ hdl/halfduplex_bus_echo_packet_mux.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// halfduplex_bus_echo_packet_mux
// Half-duplex bus transceiver: echo buffer, network frame emission and
// a ring queue of external frames delivered to the node on ticks.
//
// Input: an event beat (kind, value, last) is taken when start is high and
// busy is low. Results leave on result with strobe high for one cycle each;
// the receiver cannot stall. end_of_run marks the last result of an event.
// A tick that delivers both an echo byte and a queued byte gives its two
// results on consecutive cycles. Transmit disable emits the echo frame
// one byte per cycle. Tick and frame results wait on the registered store
// read. Reset (rst, synchronous) clears counters and flags; the stores need
// no clearing as no unwritten entry is ever read.
// ----------------------------------------------------------------------------
module halfduplex_bus_echo_packet_mux import hbepm_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire in_item_t  item,
  output      logic      busy,
  output      logic      strobe,
  output      out_item_t result
);

  cmd_t  cmd;
  stat_t stat;

  hbepm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  hbepm_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .stat   (stat),
    .strobe (strobe),
    .result (result)
  );

  // a beat is never taken while busy
  a_no_latch_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.latch |-> !busy) else $error("beat taken while busy");

  // a result is only produced while an event is in progress
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy)) else $error("result with no event");

  // the block is already idle when the final result of an event appears
  a_eor_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.end_of_run) |-> !busy) else $error("busy after end of run");

endmodule

`default_nettype wire

@@ hdl/hbepm_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hbepm_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module hbepm_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output      logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hdl/hbepm_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hbepm_ctrl
// Sequencer: decode, memory read wait, then result emission.
// ----------------------------------------------------------------------------
module hbepm_ctrl import hbepm_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire stat_t stat,
  output      logic  busy,
  output      cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_EREAD  = 3'd2;
  localparam logic [2:0] S_EMIT   = 3'd3;
  localparam logic [2:0] S_TREAD  = 3'd4;
  localparam logic [2:0] S_TICK   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.tx_off_evt) begin
          if (stat.tx_empty) begin
            cmd.emit_empty = 1'b1;
            cmd.finish     = 1'b1;
            state_next     = S_IDLE;
          end else begin
            cmd.echo_rd = 1'b1;
            state_next  = S_EREAD;
          end
        end else if (stat.tick_echo || stat.tick_queue) begin
          cmd.echo_rd  = 1'b1;
          cmd.frame_rd = 1'b1;
          state_next   = S_TREAD;
        end else begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_EREAD: begin
        // read data lands at the end of this cycle
        cmd.step_ptr = 1'b1;
        cmd.echo_rd  = 1'b1;
        state_next   = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit_echo = 1'b1;
        if (stat.ptr_last) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.step_ptr = 1'b1;
          cmd.echo_rd  = 1'b1;
        end
      end
      S_TREAD: begin
        state_next = S_TICK;
      end
      S_TICK: begin
        if (stat.tick_echo) begin
          cmd.emit_tick_e = 1'b1;
          if (!stat.tick_queue) begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end
          // second result next cycle: clear echo flag via datapath
        end else begin
          cmd.emit_tick_q = 1'b1;
          cmd.finish      = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/hbepm_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// hbepm_dp
// Datapath: echo store, frame queue, counters and the result register.
// ----------------------------------------------------------------------------
module hbepm_dp import hbepm_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire in_item_t  item,
  input  wire cmd_t      cmd,
  output      stat_t     stat,
  output      logic      strobe,
  output      out_item_t result
);

  // captured beat
  in_item_t cur;

  // control state
  logic [EchoCw-1:0] echo_fill;
  logic [EchoCw-1:0] echo_sent;
  logic [EchoAw-1:0] ptr;
  logic [SlotAw-1:0] queue_head;
  logic [CountW-1:0] queue_count;
  logic [FillCw-1:0] head_sent;
  logic [FillCw-1:0] assembly_fill;
  logic              assembly_over;
  logic              assembly_drop;
  logic              tx_enabled;
  logic              rx_enabled;
  logic              flow_on;
  logic              tick_e_pend;
  logic              tick_q_pend;

  // slot descriptors (small register arrays, read at head only)
  logic [FillCw-1:0] slot_length [QueueSlots];
  logic              slot_trunc  [QueueSlots];

  logic [7:0] echo_q;
  logic [7:0] frame_q;

  logic              level;
  logic              ext_ok;
  logic              tick_on;
  logic [SlotAw-1:0] tail;
  logic              echo_we;
  logic              frame_we;
  logic [EchoAw-1:0] echo_raddr;
  out_item_t         result_next;

  assign level  = cur.value[0];
  assign tail   = SlotAw'(queue_head + queue_count[SlotAw-1:0]);
  assign ext_ok = !(queue_count >= CountW'(QueueSlots)) && !assembly_drop;

  // tick delivers bytes only with flow and receive on
  assign tick_on = item.kind == KIND_TICK && flow_on && rx_enabled;

  assign echo_we  = cmd.latch && item.kind == KIND_NODE && tx_enabled &&
                    echo_fill < EchoCw'(EchoDepth);
  assign frame_we = cmd.latch && item.kind == KIND_EXT && ext_ok &&
                    assembly_fill < FillCw'(SlotBytes);

  // frame emission walks ptr, a tick reads at the replay position
  assign echo_raddr = (cmd.echo_rd && !cmd.frame_rd) ? ptr : echo_sent[EchoAw-1:0];

  hbepm_ram #(.Width(8), .Depth(EchoDepth)) u_echo (
    .clk   (clk),
    .we    (echo_we),
    .waddr (echo_fill[EchoAw-1:0]),
    .wdata (item.value),
    .raddr (echo_raddr),
    .rdata (echo_q)
  );

  hbepm_ram #(.Width(8), .Depth(QueueSlots * SlotBytes)) u_frame (
    .clk   (clk),
    .we    (frame_we),
    .waddr ({tail, assembly_fill[ByteAw-1:0]}),
    .wdata (item.value),
    .raddr ({queue_head, head_sent[ByteAw-1:0]}),
    .rdata (frame_q)
  );

  // status to controller; read data lags ptr by one byte
  always_comb begin
    stat.tx_off_evt = cur.kind == KIND_TXE && !level && tx_enabled;
    stat.tx_empty   = echo_fill == '0;
    stat.tick_echo  = tick_e_pend;
    stat.tick_queue = tick_q_pend;
    stat.ptr_last   = ptr == echo_fill[EchoAw-1:0];
  end

  // result selection
  always_comb begin
    result_next = '0;
    if (cmd.emit_empty) begin
      result_next.dest       = DEST_EMPTY;
      result_next.end_of_run = 1'b1;
    end else if (cmd.emit_echo) begin
      result_next.dest       = DEST_NET;
      result_next.data       = echo_q;
      result_next.frame_len  = 7'(echo_fill);
      result_next.end_of_run = cmd.finish;
    end else if (cmd.emit_tick_e) begin
      result_next.dest       = DEST_NODE;
      result_next.data       = echo_q;
      result_next.end_of_run = cmd.finish;
    end else if (cmd.emit_tick_q) begin
      result_next.dest       = DEST_NODE;
      result_next.data       = frame_q;
      result_next.truncated  = slot_trunc[queue_head];
      result_next.end_of_run = 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit_echo || cmd.emit_empty || cmd.emit_tick_e || cmd.emit_tick_q;
    end
    result <= result_next;
  end

  // slot descriptors
  always_ff @(posedge clk) begin
    if (cmd.latch && item.kind == KIND_EXT && ext_ok && item.last) begin
      slot_length[tail] <= (assembly_fill < FillCw'(SlotBytes)) ?
                           assembly_fill + FillCw'(1) : assembly_fill;
      slot_trunc[tail]  <= assembly_over || !(assembly_fill < FillCw'(SlotBytes));
    end
  end

  // state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      echo_fill     <= '0;
      echo_sent     <= '0;
      ptr           <= '0;
      queue_head    <= '0;
      queue_count   <= '0;
      head_sent     <= '0;
      assembly_fill <= '0;
      assembly_over <= 1'b0;
      assembly_drop <= 1'b0;
      tx_enabled    <= 1'b0;
      rx_enabled    <= 1'b1;
      flow_on       <= 1'b0;
      tick_e_pend   <= 1'b0;
      tick_q_pend   <= 1'b0;
    end else begin
      if (cmd.latch) begin
        cur         <= item;
        ptr         <= '0;
        // tick: decide which bytes go out
        tick_e_pend <= tick_on && echo_sent < echo_fill;
        tick_q_pend <= tick_on && queue_count != '0;
        unique case (item.kind)
          KIND_NODE: begin
            if (echo_we) echo_fill <= echo_fill + EchoCw'(1);
          end
          KIND_XON:  flow_on <= 1'b1;
          KIND_XOFF: flow_on <= 1'b0;
          KIND_EXT: begin
            if (ext_ok && item.last) queue_count <= queue_count + CountW'(1);
            if (item.last) begin
              assembly_fill <= '0;
              assembly_over <= 1'b0;
              assembly_drop <= 1'b0;
            end else if (ext_ok) begin
              if (assembly_fill < FillCw'(SlotBytes)) begin
                assembly_fill <= assembly_fill + FillCw'(1);
              end else begin
                assembly_over <= 1'b1;
              end
            end else begin
              assembly_drop <= 1'b1;
            end
          end
          default: ;
        endcase
      end

      if (cmd.step_ptr) ptr <= ptr + EchoAw'(1);

      if (cmd.emit_tick_e) begin
        echo_sent   <= echo_sent + EchoCw'(1);
        tick_e_pend <= 1'b0;
      end
      if (cmd.emit_tick_q) begin
        tick_q_pend <= 1'b0;
        if (head_sent + FillCw'(1) >= slot_length[queue_head]) begin
          queue_head  <= queue_head + SlotAw'(1);
          queue_count <= queue_count - CountW'(1);
          head_sent   <= '0;
        end else begin
          head_sent <= head_sent + FillCw'(1);
        end
      end

      // end-of-item updates for level events
      if (cmd.finish) begin
        if (cur.kind == KIND_TXE) begin
          if (level && !tx_enabled) begin
            tx_enabled <= 1'b1;
          end else if (!level && tx_enabled) begin
            tx_enabled <= 1'b0;
            echo_fill  <= '0;
            echo_sent  <= '0;
          end
        end
        if (cur.kind == KIND_RXE) begin
          if (!level && !rx_enabled) begin
            rx_enabled <= 1'b1;
          end else if (level && rx_enabled) begin
            rx_enabled <= 1'b0;
            if (echo_sent == echo_fill) begin
              if (head_sent != '0) begin
                if (queue_count != '0) begin
                  queue_head  <= queue_head + SlotAw'(1);
                  queue_count <= queue_count - CountW'(1);
                end
                head_sent <= '0;
              end
            end else begin
              echo_sent <= '0;
            end
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives event beats into the bus echo / frame queue block, predicts every
// result with a behavioural model of echo buffer and frame ring, and checks
// each result strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench import hbepm_pkg::*; ();

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  in_item_t  item = '0;
  logic      busy;
  logic      strobe;
  out_item_t result;

  halfduplex_bus_echo_packet_mux DUT (
    .clk(clk), .rst(rst), .start(start), .item(item),
    .busy(busy), .strobe(strobe), .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // behavioural state
  logic [7:0] echo_mem [EchoDepth];
  int         echo_fill, echo_sent;
  logic [7:0] frame_mem [QueueSlots*SlotBytes];
  int         slot_len [QueueSlots];
  logic       slot_cut [QueueSlots];
  int         q_head, q_count, head_sent, asm_fill;
  bit         asm_over, asm_drop, tx_on, rx_on, flow;

  out_item_t  expected_q [$];
  int         fail_count = 0;
  int         quiet_cycles = 0;
  bit         idle_ok = 1'b1;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    fail_count++;
  endtask

  function automatic void push_result(input logic [1:0] d, input logic [7:0] b,
                                      input int len, input logic cut);
    out_item_t r;
    r.dest = d; r.data = b; r.frame_len = len[6:0]; r.truncated = cut;
    r.end_of_run = 1'b0;
    expected_q.push_back(r);
  endfunction

  function automatic void drop_head();
    if (q_count > 0) begin
      q_head = (q_head + 1) % QueueSlots;
      q_count--;
    end
    head_sent = 0;
  endfunction

  // predict results of one event beat
  function automatic void predict_event(input in_item_t it);
    int n0, tail;
    bit lvl;
    n0 = expected_q.size();
    lvl = it.value[0];
    case (it.kind)
      KIND_TXE: begin
        if (lvl && !tx_on) tx_on = 1;
        else if (!lvl && tx_on) begin
          tx_on = 0;
          if (echo_fill == 0) push_result(DEST_EMPTY, 8'd0, 0, 1'b0);
          else for (int i = 0; i < echo_fill; i++)
            push_result(DEST_NET, echo_mem[i], echo_fill, 1'b0);
          echo_fill = 0; echo_sent = 0;
        end
      end
      KIND_RXE: begin
        if (!lvl && !rx_on) rx_on = 1;
        else if (lvl && rx_on) begin
          rx_on = 0;
          if (echo_sent == echo_fill) begin
            if (head_sent != 0) drop_head();
          end else echo_sent = 0;
        end
      end
      KIND_NODE: if (tx_on && echo_fill < EchoDepth) echo_mem[echo_fill++] = it.value;
      KIND_XON:  flow = 1;
      KIND_XOFF: flow = 0;
      KIND_TICK: if (flow && rx_on) begin
        if (echo_sent < echo_fill) begin
          push_result(DEST_NODE, echo_mem[echo_sent], 0, 1'b0);
          echo_sent++;
        end
        if (q_count > 0) begin
          push_result(DEST_NODE, frame_mem[q_head*SlotBytes + head_sent % SlotBytes],
                      0, slot_cut[q_head]);
          head_sent++;
          if (head_sent >= slot_len[q_head]) drop_head();
        end
      end
      KIND_EXT: begin
        if (q_count >= QueueSlots) asm_drop = 1;
        if (!asm_drop) begin
          tail = (q_head + q_count) % QueueSlots;
          if (asm_fill < SlotBytes) frame_mem[tail*SlotBytes + asm_fill++] = it.value;
          else asm_over = 1;
          if (it.last) begin
            slot_len[tail] = asm_fill; slot_cut[tail] = asm_over; q_count++;
          end
        end
        if (it.last) begin
          asm_fill = 0; asm_over = 0; asm_drop = 0;
        end
      end
      default: ;
    endcase
    if (expected_q.size() > n0) expected_q[$].end_of_run = 1'b1;
  endfunction

  // result checker
  always @(posedge clk) begin
    out_item_t e;
    if (!rst && strobe) begin
      if (expected_q.size() == 0) report($sformatf("unexpected result %p", result));
      else begin
        e = expected_q.pop_front();
        if (result.dest !== e.dest) report($sformatf("dest %0d exp %0d", result.dest, e.dest));
        if (result.data !== e.data) report($sformatf("data %h exp %h", result.data, e.data));
        if (result.frame_len !== e.frame_len)
          report($sformatf("frame_len %0d exp %0d", result.frame_len, e.frame_len));
        if (result.truncated !== e.truncated)
          report($sformatf("truncated %b exp %b", result.truncated, e.truncated));
        if (result.end_of_run !== e.end_of_run)
          report($sformatf("end_of_run %b exp %b", result.end_of_run, e.end_of_run));
      end
    end
  end

  // watchdog on cycles without any beat or result
  always @(posedge clk) begin
    if ((start && !busy) || strobe || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("testbench failed");
      $finish;
    end
  end

  // send one beat; random idle gaps when allowed
  task automatic send_event(input logic [2:0] k, input logic [7:0] v, input logic l);
    in_item_t it;
    it.kind = k; it.value = v; it.last = l;
    while (idle_ok && $urandom_range(99) < 13) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_event(it);
    // block is idle again here; drop start so no further beat is taken
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_frame(input int len, input bit rnd);
    for (int i = 0; i < len; i++)
      send_event(KIND_EXT, rnd ? 8'($urandom) : 8'(i), i == len - 1);
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_directed();
    send_event(KIND_TXE, 8'h01, 1'b0);
    send_event(KIND_TXE, 8'h00, 1'b0);          // empty network frame
    send_event(KIND_TXE, 8'h00, 1'b0);          // already off
    send_event(KIND_NODE, 8'hFF, 1'b0);         // dropped, transmit off
    send_event(KIND_TXE, 8'hFF, 1'b0);
    send_event(KIND_TXE, 8'h01, 1'b0);          // already on
    send_event(KIND_NODE, 8'h00, 1'b0);
    send_event(KIND_NODE, 8'hFF, 1'b0);
    send_event(KIND_TICK, 8'h00, 1'b0);         // flow off
    send_event(KIND_XON, 8'h00, 1'b0);
    send_event(KIND_TICK, 8'h00, 1'b0);
    send_event(KIND_RXE, 8'h01, 1'b0);          // restart echo replay
    send_event(KIND_RXE, 8'h01, 1'b0);
    send_event(KIND_TICK, 8'h00, 1'b0);         // receive off
    send_event(KIND_RXE, 8'h00, 1'b0);
    send_event(KIND_RXE, 8'h00, 1'b0);
    send_event(KIND_TXE, 8'hFE, 1'b0);
    send_event(3'd7, 8'hAA, 1'b1);              // unused kind
    send_event(KIND_XOFF, 8'h55, 1'b0);
    send_event(KIND_XON, 8'h00, 1'b0);
    wait_drained();                             // sender holds off until drained
  endtask

  // echo buffer overflow and largest network frame, back to back
  task automatic test_echo_full();
    idle_ok = 1'b0;
    send_event(KIND_TXE, 8'h01, 1'b0);
    for (int i = 0; i < EchoDepth + 1; i++) send_event(KIND_NODE, 8'($urandom), 1'b0);
    send_event(KIND_TXE, 8'h00, 1'b0);
    idle_ok = 1'b1;
  endtask

  // truncated frame, full queue, head discard on receive disable
  task automatic test_queue();
    send_event(KIND_XOFF, 8'h00, 1'b0);
    for (int i = 0; i < QueueSlots - 1; i++) send_frame(1, 1'b1);
    send_frame(SlotBytes + 1, 1'b1);             // truncated, queue now full
    send_frame(2, 1'b1);                         // dropped, queue full
    send_event(KIND_XON, 8'h00, 1'b0);
    send_event(KIND_EXT, 8'h12, 1'b0);           // dropped, queue full
    send_event(KIND_TICK, 8'h00, 1'b0);          // frees a slot
    send_event(KIND_EXT, 8'h34, 1'b1);           // still dropped
    for (int i = 0; i < QueueSlots + 1; i++) send_event(KIND_TICK, 8'h00, 1'b0);
    send_event(KIND_RXE, 8'h01, 1'b0);           // discard partly sent head
    send_event(KIND_RXE, 8'h00, 1'b0);
    for (int i = 0; i < 4; i++) send_event(KIND_TICK, 8'h00, 1'b0);
  endtask

  task automatic test_random();
    int r;
    for (int i = 0; i < 25; i++) begin
      r = $urandom_range(99);
      if (r < 30) send_event(KIND_TICK, 8'($urandom), 1'($urandom));
      else if (r < 48) send_event(KIND_NODE, 8'($urandom), 1'($urandom));
      else if (r < 62) send_frame($urandom_range(1, 6), 1'b1);
      else if (r < 72) send_event(KIND_TXE, 8'($urandom), 1'($urandom));
      else if (r < 80) send_event(KIND_RXE, {7'($urandom), 1'($urandom_range(99) < 30)},
                                  1'($urandom));
      else if (r < 90) send_event(KIND_XON, 8'($urandom), 1'($urandom));
      else if (r < 94) send_event(KIND_XOFF, 8'($urandom), 1'($urandom));
      else if (r < 98) send_event(KIND_EXT, 8'($urandom), 1'($urandom));
      else send_event(3'd7, 8'($urandom), 1'($urandom));
    end
    idle_ok = 1'b1;
  endtask

  initial begin
    echo_fill = 0; echo_sent = 0; q_head = 0; q_count = 0; head_sent = 0;
    asm_fill = 0; asm_over = 0; asm_drop = 0; tx_on = 0; rx_on = 1; flow = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_echo_full();
    test_queue();
    test_random();
    send_event(KIND_TXE, 8'h00, 1'b0);
    wait_drained();
    repeat (80) @(posedge clk);
    if (fail_count == 0 && expected_q.size() == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end
endmodule
